// ----- sv/bir_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bir_pkg: shared types and constants for the bilinear image rotator
// Control words between sequencer and datapath, register indexes, fixed-point
// constants of the mapping and the lane blend.
// ----------------------------------------------------------------------------
package bir_pkg;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_COS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN = 2'd1;

   // Register and pixel widths
   localparam int TRIG_W  = 18;
   localparam int PIXEL_W = 32;
   localparam int LANE_W  = 8;
   localparam int LANES   = PIXEL_W / LANE_W;

   // Fixed-point mapping: product scale is 2^16, position grid is 1/16 pixel
   localparam int TRUNC_SH   = 12;
   localparam int FRAC_W     = 4;
   localparam logic [4:0] FRAC_ONE = 5'd16;

   // Blend: weights out of 256, rounding by half of 256
   localparam int WEIGHT_W   = 9;
   localparam int BLEND_ACC_W = 16;
   localparam logic [BLEND_ACC_W-1:0] BLEND_ROUND = 16'd128;
   localparam int BLEND_SH   = 8;

   // Order of the four products through the shared multiplier
   typedef enum logic [1:0] {
      STEP_DXC = 2'd0,   // dx * cos
      STEP_DYS = 2'd1,   // dy * sin
      STEP_DYC = 2'd2,   // dy * cos
      STEP_DXS = 2'd3    // dx * sin
   } mul_step_type;

   typedef struct packed {
      logic         clear;
      logic         mul_en;
      mul_step_type step;
      logic         map_en;
   } map_ctl_type;

   typedef struct packed {
      logic clear;
      logic acc;
   } blend_ctl_type;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_LOAD  = 8'b0000_0010,
      ST_MUL   = 8'b0000_0100,
      ST_ACC   = 8'b0000_1000,
      ST_MAP   = 8'b0001_0000,
      ST_READ  = 8'b0010_0000,
      ST_DRAIN = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

endpackage

// ----- sv/bir_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bir_ram: generic single-port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module bir_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write on we, otherwise read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end else begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/bir_mapper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bir_mapper: rotation mapping with one shared multiplier
// Runs dx*cos, dy*sin, dy*cos, dx*sin through one registered multiplier,
// accumulates the two source coordinates, then truncates to the 1/16 grid
// and splits integer position and fraction.
// ----------------------------------------------------------------------------
module bir_mapper
   import bir_pkg::*;
#(
   parameter int IMG_SIZE = 240
) (
   input  logic                          clock,
   input  logic                          reset,
   input  map_ctl_type                   ctl,
   input  logic [7:0]                    row,
   input  logic [7:0]                    col,
   input  logic signed [TRIG_W-1:0]      cos_val,
   input  logic signed [TRIG_W-1:0]      sin_val,
   output logic [$clog2(IMG_SIZE)-1:0]   map_xp,
   output logic [$clog2(IMG_SIZE)-1:0]   map_yp,
   output logic [FRAC_W-1:0]             map_xf,
   output logic [FRAC_W-1:0]             map_yf,
   output logic                          map_off
);

   localparam int XW = $clog2(IMG_SIZE);
   localparam int DW = $clog2(IMG_SIZE + 256) + 1;
   localparam int PW = DW + TRIG_W;
   localparam int AW = PW + 1;
   localparam logic signed [DW-1:0] CEN_D = DW'(IMG_SIZE / 2);
   localparam logic signed [AW-1:0] CEN_A = AW'(IMG_SIZE / 2);
   localparam logic signed [AW-1:0] LIM_A = AW'(IMG_SIZE - 2);
   localparam logic signed [AW-1:0] BIAS_A = AW'((1 << TRUNC_SH) - 1);

   logic signed [DW-1:0] dx, dy, a_sel;
   logic signed [TRIG_W-1:0] b_sel;
   logic signed [PW-1:0] prod_in, prod_ff;
   mul_step_type pstep_ff;
   logic pvalid_ff;
   logic signed [AW-1:0] xacc_ff, xacc_in, yacc_ff, yacc_in;
   logic signed [AW-1:0] xb, yb, xm, ym, xp, yp;
   logic [XW-1:0] xp_ff, yp_ff;
   logic [FRAC_W-1:0] xf_ff, yf_ff;

   // Offsets from the image center
   assign dx = CEN_D - $signed({{(DW-8){1'b0}}, col});
   assign dy = CEN_D - $signed({{(DW-8){1'b0}}, row});

   // Select operands of the shared multiplier
   always_comb begin
      case (ctl.step)
         STEP_DXC: begin a_sel = dx; b_sel = cos_val; end
         STEP_DYS: begin a_sel = dy; b_sel = sin_val; end
         STEP_DYC: begin a_sel = dy; b_sel = cos_val; end
         default:  begin a_sel = dx; b_sel = sin_val; end
      endcase
   end

   assign prod_in = PW'(a_sel) * PW'(b_sel);

   // Register the product
   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
      end else begin
         pvalid_ff <= ctl.mul_en;
      end
      prod_ff  <= prod_in;
      pstep_ff <= ctl.step;
   end

   // Accumulate: x = -dx*cos - dy*sin, y = -dy*cos + dx*sin
   always_comb begin
      xacc_in = xacc_ff;
      yacc_in = yacc_ff;
      if (ctl.clear) begin
         xacc_in = '0;
         yacc_in = '0;
      end else if (pvalid_ff) begin
         case (pstep_ff)
            STEP_DXC: xacc_in = xacc_ff - AW'(prod_ff);
            STEP_DYS: xacc_in = xacc_ff - AW'(prod_ff);
            STEP_DYC: yacc_in = yacc_ff - AW'(prod_ff);
            default:  yacc_in = yacc_ff + AW'(prod_ff);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      xacc_ff <= xacc_in;
      yacc_ff <= yacc_in;
   end

   // Truncate toward zero onto the 1/16 grid, then floor to whole pixels
   assign xb = xacc_ff + (xacc_ff[AW-1] ? BIAS_A : '0);
   assign yb = yacc_ff + (yacc_ff[AW-1] ? BIAS_A : '0);
   assign xm = xb >>> TRUNC_SH;
   assign ym = yb >>> TRUNC_SH;
   assign xp = (xm >>> FRAC_W) + CEN_A;
   assign yp = (ym >>> FRAC_W) + CEN_A;

   assign map_off = (xp < 0) || (yp < 0) || (xp > LIM_A) || (yp > LIM_A);

   // Hold the mapped position for the neighbor reads
   always_ff @(posedge clock) begin
      if (ctl.map_en) begin
         xp_ff <= xp[XW-1:0];
         yp_ff <= yp[XW-1:0];
         xf_ff <= xm[FRAC_W-1:0];
         yf_ff <= ym[FRAC_W-1:0];
      end
   end

   assign map_xp = xp_ff;
   assign map_yp = yp_ff;
   assign map_xf = xf_ff;
   assign map_yf = yf_ff;

endmodule

// ----- sv/bir_blend.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bir_blend: per-lane weighted accumulation of neighbor words
// Adds weight times lane value for each of the four byte lanes, one neighbor
// word per cycle while acc is set, and rounds the sums down by 256.
// ----------------------------------------------------------------------------
module bir_blend
   import bir_pkg::*;
(
   input  logic                clock,
   input  blend_ctl_type       ctl,
   input  logic [WEIGHT_W-1:0] weight,
   input  logic [PIXEL_W-1:0]  word,
   output logic [PIXEL_W-1:0]  pixel
);

   localparam int PRW = WEIGHT_W + LANE_W;

   logic [BLEND_ACC_W-1:0] acc_ff [LANES];
   logic [BLEND_ACC_W-1:0] acc_in [LANES];
   logic [PRW-1:0]         lane_prod [LANES];
   logic [BLEND_ACC_W-1:0] rounded [LANES];

   // Multiply-accumulate each lane
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         lane_prod[k] = PRW'(weight) * PRW'(word[k*LANE_W +: LANE_W]);
         if (ctl.clear) begin
            acc_in[k] = '0;
         end else if (ctl.acc) begin
            acc_in[k] = acc_ff[k] + lane_prod[k][BLEND_ACC_W-1:0];
         end else begin
            acc_in[k] = acc_ff[k];
         end
         rounded[k] = acc_ff[k] + BLEND_ROUND;
         pixel[k*LANE_W +: LANE_W] = rounded[k][BLEND_SH +: LANE_W];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < LANES; k++) begin
         acc_ff[k] <= acc_in[k];
      end
   end

endmodule

// ----- sv/bilinear_image_rotate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_image_rotate: rotate a square image with bilinear interpolation
// Loads write source pixels into the image RAM; queries map an output pixel
// back into the source and blend its four neighbors per byte lane.
//
//   channel  handshake               payload
//   req      start / busy            req_mode, req_row, req_col, req_pixel_in
//   rsp      rsp_valid (strobe)      rsp_pixel_out, rsp_off_edge
//   csr      csr_valid / csr_ready   csr_index, csr_wdata
//
// A load passes through the load state and back to idle. A query makes four
// passes through the shared multiplier, accumulate and map, then four reads
// of the single-port image RAM and a drain before the result; off the edge
// it goes from map straight to the result. The result shows one cycle on
// rsp_valid while the next word may already be accepted; the receiver cannot
// stall it. Reset clears control and restores cos = 65536, sin = 0; the image
// RAM is not cleared and reads of unwritten pixels return whatever it holds.
// ----------------------------------------------------------------------------
module bilinear_image_rotate
   import bir_pkg::*;
#(
   parameter int IMG_SIZE = 240
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_mode,
   input  logic [7:0]            req_row,
   input  logic [7:0]            req_col,
   input  logic [PIXEL_W-1:0]    req_pixel_in,
   output logic                  rsp_valid,
   output logic [PIXEL_W-1:0]    rsp_pixel_out,
   output logic                  rsp_off_edge,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [TRIG_W-1:0]     csr_wdata
);

   localparam int XW  = $clog2(IMG_SIZE);
   localparam int ADW = $clog2(IMG_SIZE * IMG_SIZE);

   state_type state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;
   logic accept;
   logic [7:0] row_ff, col_ff;
   logic [PIXEL_W-1:0] pix_ff;
   logic signed [TRIG_W-1:0] cos_ff, sin_ff;
   logic off_ff, off_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_off_ff;
   logic [PIXEL_W-1:0] rsp_pixel_ff;
   logic [WEIGHT_W-1:0] wt_ff;
   logic dv_ff;

   map_ctl_type map_ctl;
   blend_ctl_type blend_ctl;
   logic [XW-1:0] map_xp, map_yp;
   logic [FRAC_W-1:0] map_xf, map_yf;
   logic map_off;

   logic [XW+7:0] row_w, col_w;
   logic [XW-1:0] addr_r, addr_c;
   logic [ADW-1:0] ram_addr;
   logic ram_we;
   logic [PIXEL_W-1:0] ram_rdata, blend_pixel;
   logic [4:0] wx, wy;
   logic [9:0] wprod;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff <= TRIG_W'(65536);
         sin_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COS: cos_ff <= $signed(csr_wdata);
            CSR_SIN: sin_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // Capture the request word
   always_ff @(posedge clock) begin
      if (accept) begin
         row_ff <= req_row;
         col_ff <= req_col;
         pix_ff <= req_pixel_in;
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      off_in       = off_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               state_in = req_mode ? ST_MUL : ST_LOAD;
            end
         end
         ST_LOAD: state_in = ST_IDLE;
         ST_MUL: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: state_in = ST_MAP;
         ST_MAP: begin
            off_in   = map_off;
            cnt_in   = '0;
            state_in = map_off ? ST_DONE : ST_READ;
         end
         ST_READ: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_DONE;
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         off_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dv_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         off_ff       <= off_in;
         rsp_valid_ff <= rsp_valid_in;
         dv_ff        <= (state_ff == ST_READ);
      end
   end

   // Drive the mapper
   assign map_ctl.clear  = accept;
   assign map_ctl.mul_en = (state_ff == ST_MUL);
   assign map_ctl.step   = mul_step_type'(cnt_ff);
   assign map_ctl.map_en = (state_ff == ST_MAP);

   bir_mapper #(
      .IMG_SIZE (IMG_SIZE)
   ) u_mapper (
      .clock   (clock),
      .reset   (reset),
      .ctl     (map_ctl),
      .row     (row_ff),
      .col     (col_ff),
      .cos_val (cos_ff),
      .sin_val (sin_ff),
      .map_xp  (map_xp),
      .map_yp  (map_yp),
      .map_xf  (map_xf),
      .map_yf  (map_yf),
      .map_off (map_off)
   );

   // Image address: load position, or neighbor selected by the read count
   assign row_w = {{XW{1'b0}}, row_ff};
   assign col_w = {{XW{1'b0}}, col_ff};
   always_comb begin
      if (state_ff == ST_READ) begin
         addr_r = map_yp + XW'(cnt_ff[1]);
         addr_c = map_xp + XW'(cnt_ff[0]);
      end else begin
         addr_r = row_w[XW-1:0];
         addr_c = col_w[XW-1:0];
      end
   end
   assign ram_addr = ADW'(addr_r) * ADW'(IMG_SIZE) + ADW'(addr_c);

   // Drop loads outside the image
   assign ram_we = (state_ff == ST_LOAD) && (row_w < (XW + 8)'(IMG_SIZE))
                   && (col_w < (XW + 8)'(IMG_SIZE));

   bir_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (IMG_SIZE * IMG_SIZE)
   ) u_image (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (pix_ff),
      .rdata (ram_rdata)
   );

   // Neighbor weight, aligned with the registered read data
   assign wx    = cnt_ff[0] ? {1'b0, map_xf} : FRAC_ONE - {1'b0, map_xf};
   assign wy    = cnt_ff[1] ? {1'b0, map_yf} : FRAC_ONE - {1'b0, map_yf};
   assign wprod = 10'(wx) * 10'(wy);

   always_ff @(posedge clock) begin
      wt_ff <= wprod[WEIGHT_W-1:0];
   end

   assign blend_ctl.clear = accept;
   assign blend_ctl.acc   = dv_ff;

   bir_blend u_blend (
      .clock  (clock),
      .ctl    (blend_ctl),
      .weight (wt_ff),
      .word   (ram_rdata),
      .pixel  (blend_pixel)
   );

   // Result word
   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE) begin
         rsp_pixel_ff <= off_ff ? '0 : blend_pixel;
         rsp_off_ff   <= off_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_off_edge  = rsp_off_ff;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for bilinear_image_rotate
// Loads source pixels and queries rotated pixels under a series of sine and
// cosine settings. A directed table comes first, then random loads and
// queries. Directed hit and off-edge rows expect table values; the other
// results are checked against an in-bench fixed-point rotation predictor
// with its own copy of image and registers. Queries read only loaded pixels.
// ----------------------------------------------------------------------------
module tb
   import bir_pkg::*;
();

   localparam int IMG_SIZE        = 240;
   localparam int IMG_N           = IMG_SIZE * IMG_SIZE;
   localparam int HALF            = IMG_SIZE / 2;
   localparam int CLK_PERIOD      = 10;
   localparam int SETTLE          = 16;     // longer than the slowest query
   localparam int QUIET_LIMIT     = 2000;
   localparam int WORDS_PER_PHASE = 41;
   localparam int PHASES          = 11;
   localparam int FIXED_PHASES    = 8;
   localparam int DIR_N           = 30;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // register indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef enum logic [2:0] {
      ROW_LOAD,        // load a source pixel
      ROW_QUERY,       // query, checked against the predictor
      ROW_QUERY_HIT,   // query, expect data with off_edge low
      ROW_QUERY_OFF,   // query, expect zero with off_edge high
      ROW_CSR          // register write, data holds the value
   } stim_kind_type;

   typedef struct {
      stim_kind_type            kind;
      logic [CSR_IDX_W-1:0]     reg_idx;   // used by register rows only
      logic [7:0]               row;
      logic [7:0]               col;
      logic [31:0]              data;
   } stim_row_type;

   typedef struct {
      logic [PIXEL_W-1:0] pixel;
      logic               off;
   } rot_rsp_type;

   typedef struct {
      bit off;
      int xp;
      int yp;
      int xf;
      int yf;
   } src_pos_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_mode;
   logic [7:0]           req_row;
   logic [7:0]           req_col;
   logic [PIXEL_W-1:0]   req_pixel_in;
   logic                 rsp_valid;
   logic [PIXEL_W-1:0]   rsp_pixel_out;
   logic                 rsp_off_edge;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TRIG_W-1:0]    csr_wdata;

   // predictor state: image copy, written flags, rotation registers
   logic [PIXEL_W-1:0] src_img [0:IMG_N-1];
   bit                 src_written [0:IMG_N-1];
   longint             cos_q;
   longint             sin_q;
   rot_rsp_type        expected_rot [$];

   int errors       = 0;
   int quiet_cycles = 0;
   int items_done   = 0;
   int no_idle_left = 0;

   int cos_pick [FIXED_PHASES] = '{65536, -65536, 0, 0, 131071, -131072, 46341, 60547};
   int sin_pick [FIXED_PHASES] = '{0, 0, 65536, -65536, -131072, 131071, 46341, 25080};

   // directed stimulus; the first part runs at reset setting (identity)
   stim_row_type dir_tab [DIR_N] = '{
      '{ROW_LOAD,      CSR_COS,     8'd0,   8'd0,   32'hFFFF_FFFF},
      '{ROW_LOAD,      CSR_COS,     8'd0,   8'd1,   32'h0000_0000},
      '{ROW_LOAD,      CSR_COS,     8'd1,   8'd0,   32'h0000_0000},
      '{ROW_LOAD,      CSR_COS,     8'd1,   8'd1,   32'h0000_0000},
      '{ROW_LOAD,      CSR_COS,     8'd2,   8'd0,   32'hA5A5_A5A5},
      '{ROW_LOAD,      CSR_COS,     8'd2,   8'd1,   32'h5A5A_5A5A},
      '{ROW_QUERY_HIT, CSR_COS,     8'd0,   8'd0,   32'hFFFF_FFFF},
      '{ROW_LOAD,      CSR_COS,     8'd238, 8'd238, 32'h80FF_0001},
      '{ROW_LOAD,      CSR_COS,     8'd238, 8'd239, 32'hFFFF_FFFF},
      '{ROW_LOAD,      CSR_COS,     8'd239, 8'd238, 32'hFFFF_FFFF},
      '{ROW_LOAD,      CSR_COS,     8'd239, 8'd239, 32'hFFFF_FFFF},
      '{ROW_QUERY_HIT, CSR_COS,     8'd238, 8'd238, 32'h80FF_0001},
      // last row and column have no right or lower neighbor
      '{ROW_QUERY_OFF, CSR_COS,     8'd239, 8'd0,   32'h0},
      '{ROW_QUERY_OFF, CSR_COS,     8'd0,   8'd239, 32'h0},
      '{ROW_QUERY_OFF, CSR_COS,     8'd255, 8'd255, 32'h0},
      // out-of-range loads are dropped; row 0 col 240 would alias row 1 col 0
      '{ROW_LOAD,      CSR_COS,     8'd0,   8'd240, 32'hDEAD_BEEF},
      '{ROW_LOAD,      CSR_COS,     8'd240, 8'd0,   32'hDEAD_BEEF},
      '{ROW_LOAD,      CSR_COS,     8'd255, 8'd255, 32'hDEAD_BEEF},
      '{ROW_QUERY_HIT, CSR_COS,     8'd1,   8'd0,   32'h0000_0000},
      '{ROW_CSR,       CSR_SPARE_A, 8'd0,   8'd0,   32'h0003_FFFF},
      '{ROW_QUERY_HIT, CSR_COS,     8'd0,   8'd0,   32'hFFFF_FFFF},
      // quarter turn: an out-of-range query lands inside the image
      '{ROW_CSR,       CSR_SIN,     8'd0,   8'd0,   32'(65536)},
      '{ROW_CSR,       CSR_COS,     8'd0,   8'd0,   32'(0)},
      '{ROW_QUERY,     CSR_COS,     8'd5,   8'd240, 32'h0},
      // half turn
      '{ROW_CSR,       CSR_COS,     8'd0,   8'd0,   32'(-65536)},
      '{ROW_CSR,       CSR_SIN,     8'd0,   8'd0,   32'(0)},
      '{ROW_QUERY,     CSR_COS,     8'd10,  8'd20,  32'h0},
      // eighth turn: fractional positions
      '{ROW_CSR,       CSR_COS,     8'd0,   8'd0,   32'(46341)},
      '{ROW_CSR,       CSR_SIN,     8'd0,   8'd0,   32'(46341)},
      '{ROW_QUERY,     CSR_COS,     8'd30,  8'd200, 32'h0}
   };

   bilinear_image_rotate #(
      .IMG_SIZE(IMG_SIZE)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_mode      (req_mode),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_off_edge  (rsp_off_edge),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // map an output position back into the source on the 1/16-pixel grid
   function automatic src_pos_type map_to_source(input logic [7:0] row, input logic [7:0] col);
      src_pos_type p;
      longint      dx;
      longint      dy;
      longint      xm;
      longint      ym;
      dx = longint'(HALF) - longint'(col);
      dy = longint'(HALF) - longint'(row);
      // signed division truncates toward zero
      xm = (-dx * cos_q - dy * sin_q) / (longint'(1) << TRUNC_SH);
      ym = (-dy * cos_q + dx * sin_q) / (longint'(1) << TRUNC_SH);
      p.xp  = int'(longint'(HALF) + (xm >>> FRAC_W));
      p.yp  = int'(longint'(HALF) + (ym >>> FRAC_W));
      p.xf  = int'(xm & ((longint'(1) << FRAC_W) - 1));
      p.yf  = int'(ym & ((longint'(1) << FRAC_W) - 1));
      p.off = (p.xp < 0) || (p.yp < 0) || (p.xp > IMG_SIZE - 2) || (p.yp > IMG_SIZE - 2);
      return p;
   endfunction

   // blend the four neighbors per byte lane, weights out of 256
   function automatic rot_rsp_type rotate_pixel(input logic [7:0] row, input logic [7:0] col);
      rot_rsp_type        r;
      src_pos_type        p;
      logic [PIXEL_W-1:0] w00;
      logic [PIXEL_W-1:0] w10;
      logic [PIXEL_W-1:0] w01;
      logic [PIXEL_W-1:0] w11;
      int                 base;
      int                 one;
      int                 s;
      int                 k;
      p       = map_to_source(row, col);
      one     = int'(FRAC_ONE);
      r.pixel = '0;
      r.off   = p.off;
      if (!p.off) begin
         base = p.yp * IMG_SIZE + p.xp;
         w00  = src_img[base];
         w10  = src_img[base + 1];
         w01  = src_img[base + IMG_SIZE];
         w11  = src_img[base + IMG_SIZE + 1];
         for (k = 0; k < LANES; k++) begin
            s = (one - p.xf) * (one - p.yf) * int'(w00[LANE_W*k +: LANE_W])
              + p.xf * (one - p.yf) * int'(w10[LANE_W*k +: LANE_W])
              + (one - p.xf) * p.yf * int'(w01[LANE_W*k +: LANE_W])
              + p.xf * p.yf * int'(w11[LANE_W*k +: LANE_W])
              + int'(BLEND_ROUND);
            r.pixel[LANE_W*k +: LANE_W] = LANE_W'(s >> BLEND_SH);
         end
      end
      return r;
   endfunction

   // draw the gap before the next word; now and then a stretch with no gaps
   function automatic int draw_gap();
      if (no_idle_left > 0) begin
         no_idle_left--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         no_idle_left = $urandom_range(8, 24);
         return 0;
      end
      return $urandom_range(0, 8);
   endfunction

   function automatic logic [PIXEL_W-1:0] draw_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return PIXEL_W'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] draw_coord();
      if ($urandom_range(0, 9) == 0)
         return 8'($urandom_range(IMG_SIZE, 255));
      return 8'($urandom_range(0, IMG_SIZE - 1));
   endfunction

   // drive one word and hold it until the block takes it
   task automatic issue_word(input logic mode, input logic [7:0] row, input logic [7:0] col,
                             input logic [PIXEL_W-1:0] pix);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_mode     <= mode;
      req_row      <= row;
      req_col      <= col;
      req_pixel_in <= pix;
      do @(posedge clock); while (busy);
   endtask

   task automatic send_load(input logic [7:0] row, input logic [7:0] col,
                            input logic [PIXEL_W-1:0] pix);
      issue_word(MODE_LOAD, row, col, pix);
      if (row < IMG_SIZE && col < IMG_SIZE) begin
         src_img[row * IMG_SIZE + col]     = pix;
         src_written[row * IMG_SIZE + col] = 1'b1;
         items_done++;
      end
   endtask

   task automatic send_query(input logic [7:0] row, input logic [7:0] col);
      src_pos_type p;
      int          r;
      int          c;
      p = map_to_source(row, col);
      // load any neighbor never written so the query reads known pixels only
      if (!p.off) begin
         for (r = p.yp; r <= p.yp + 1; r++)
            for (c = p.xp; c <= p.xp + 1; c++)
               if (!src_written[r * IMG_SIZE + c])
                  send_load(8'(r), 8'(c), draw_pixel());
      end
      issue_word(MODE_QUERY, row, col, draw_pixel());
      expected_rot.push_back(rotate_pixel(row, col));
      items_done++;
   endtask

   // wait for every pending result, then let a trailing load finish
   task automatic wait_drained();
      while (expected_rot.size() != 0) @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [TRIG_W-1:0] val);
      start <= 1'b0;
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_COS: cos_q = longint'(signed'(val));
         CSR_SIN: sin_q = longint'(signed'(val));
         default: ;
      endcase
   endtask

   // check each result word against the oldest expectation; count quiet cycles
   always @(posedge clock) begin
      rot_rsp_type want;
      if (!reset) begin
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (rsp_valid) begin
            if (expected_rot.size() == 0) begin
               errors++;
               $display("%0t: result with none pending, expected nothing, got %08h off_edge %0b",
                        $time, rsp_pixel_out, rsp_off_edge);
            end else begin
               want = expected_rot.pop_front();
               if (rsp_pixel_out !== want.pixel) begin
                  errors++;
                  $display("%0t: pixel_out mismatch, expected %08h, got %08h",
                           $time, want.pixel, rsp_pixel_out);
               end
               if (rsp_off_edge !== want.off) begin
                  errors++;
                  $display("%0t: off_edge mismatch, expected %0b, got %0b",
                           $time, want.off, rsp_off_edge);
               end
            end
         end
      end
   end

   // watchdog: stop when nothing moves for too long
   initial begin
      do @(negedge clock); while (quiet_cycles < QUIET_LIMIT);
      $display("bilinear_image_rotate test failed");
      $finish;
   end

   initial begin
      rot_rsp_type known;
      int          n;
      int          p;
      int          pick;
      int          budget;
      int          cs;
      int          sn;

      reset        = 1'b1;
      start        = 1'b0;
      req_mode     = MODE_LOAD;
      req_row      = '0;
      req_col      = '0;
      req_pixel_in = '0;
      csr_valid    = 1'b0;
      csr_index    = CSR_COS;
      csr_wdata    = '0;
      cos_q        = 65536;
      sin_q        = 0;
      for (n = 0; n < IMG_N; n++)
         src_written[n] = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (n = 0; n < DIR_N; n++) begin
         case (dir_tab[n].kind)
            ROW_LOAD:  send_load(dir_tab[n].row, dir_tab[n].col, dir_tab[n].data);
            ROW_QUERY: send_query(dir_tab[n].row, dir_tab[n].col);
            ROW_QUERY_HIT, ROW_QUERY_OFF: begin
               issue_word(MODE_QUERY, dir_tab[n].row, dir_tab[n].col, draw_pixel());
               known.off   = (dir_tab[n].kind == ROW_QUERY_OFF);
               known.pixel = known.off ? '0 : dir_tab[n].data;
               expected_rot.push_back(known);
            end
            ROW_CSR:   write_csr(dir_tab[n].reg_idx, TRIG_W'(dir_tab[n].data));
            default: ;
         endcase
      end

      // random phases: fixed angles and register extremes, then random settings
      items_done = 0;
      for (p = 0; p < PHASES; p++) begin
         if (p < FIXED_PHASES) begin
            cs = cos_pick[p];
            sn = sin_pick[p];
         end else if (p < PHASES - 1) begin
            cs = int'($urandom_range(0, 131072)) - 65536;
            sn = int'($urandom_range(0, 131072)) - 65536;
         end else begin
            cs = int'($urandom);
            sn = int'($urandom);
         end
         write_csr(CSR_COS, TRIG_W'(cs));
         write_csr(CSR_SIN, TRIG_W'(sn));
         if (p == 0 || $urandom_range(0, 2) == 0)
            write_csr(CSR_SPARE_B, TRIG_W'($urandom));
         budget = items_done + WORDS_PER_PHASE;
         while (items_done < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
               send_query(draw_coord(), draw_coord());
            else if (pick < 90)
               send_load(8'($urandom_range(0, IMG_SIZE - 1)),
                         8'($urandom_range(0, IMG_SIZE - 1)), draw_pixel());
            else if (pick < 95)
               send_load(8'($urandom_range(IMG_SIZE, 255)), 8'($urandom), draw_pixel());
            else
               send_load(8'($urandom), 8'($urandom_range(IMG_SIZE, 255)), draw_pixel());
         end
      end

      start <= 1'b0;
      wait_drained();
      if (errors == 0)
         $display("bilinear_image_rotate test passed");
      else
         $display("bilinear_image_rotate test failed");
      $finish;
   end

endmodule
